/* rtl/ogn_pkg.sv */
// Shared types, constants and arithmetic helpers for the octave gradient noise core.
// No dependencies; the core, the octave lane and both bench files refer to it by scoped names.
`default_nettype none

package ogn_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int MAX_OCTAVES = 8;
  localparam int TABLE_SIZE  = 256;
  localparam int IDX_W       = $clog2(TABLE_SIZE);
  localparam int COORD_W     = 8 + FRAC_BITS;
  localparam int OCT_W       = 4;
  localparam int NSTG        = 11;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_EVAL = 1'b1
  } req_t;

  // table write stream for the three lookup levels
  typedef struct packed {
    logic [2:0]            we;
    logic [2:0][IDX_W-1:0] idx;
    logic [2:0][7:0]       val;
  } tbl_wr_t;

  // divide by 2^FRAC_BITS, round to nearest, ties up
  function automatic logic signed [47:0] rnd_frac(input logic signed [47:0] v);
    return (v + (48'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [18:0] grad(input logic [3:0] h,
                                               input logic signed [17:0] gx,
                                               input logic signed [17:0] gy);
    logic signed [18:0] u;
    logic signed [18:0] v;
    u = (h < 4'd8) ? 19'(gx) : 19'(gy);
    if (h < 4'd4) begin
      v = 19'(gy);
    end else if (h == 4'd12 || h == 4'd14) begin
      v = 19'(gx);
    end else begin
      v = 19'sd0;
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage

`default_nettype wire

/* rtl/ogn_in_if.sv */
// Input channel of the noise core: table loads and evaluate points.
// Depends on nothing.
`default_nettype none

interface ogn_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [7:0]         table_index;
  logic [7:0]         table_value;
  logic signed [23:0] x_coord;
  logic signed [23:0] y_coord;

  modport source (output valid, req_type, table_index, table_value, x_coord, y_coord,
                  input ready);
  modport sink (input valid, req_type, table_index, table_value, x_coord, y_coord,
                output ready);
endinterface

`default_nettype wire

/* rtl/ogn_out_if.sv */
// Result channel of the noise core: raw octave sum and unit-range value.
// Depends on nothing.
`default_nettype none

interface ogn_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] raw_sum;
  logic [15:0]        noise_unit;

  modport source (output valid, raw_sum, noise_unit, input ready);
  modport sink (input valid, raw_sum, noise_unit, output ready);
endinterface

`default_nettype wire

/* rtl/octave_gradient_noise_2d_core.sv */
// Fractal 2D gradient noise: eight octave lanes with private table copies, a sum tree
// and output scaling. Throughput: one beat per cycle, loads and points alike; the whole
// pipeline holds while a result waits. Reset clears the valid bits and sets octave_count
// to 1; the permutation table is not cleared.
// Depends on ogn_pkg, ogn_in_if, ogn_out_if and ogn_octave.
`default_nettype none

module octave_gradient_noise_2d_core (
  input  logic                         clk,
  input  logic                         rst,
  ogn_in_if.sink                       item,
  ogn_out_if.source                    result,
  input  logic                         cfg_wr_en,
  input  logic [ogn_pkg::OCT_W-1:0]    cfg_wr_data
);

  localparam int NSTG = ogn_pkg::NSTG;
  localparam int NOCT = ogn_pkg::MAX_OCTAVES;
  localparam int CW   = ogn_pkg::COORD_W;
  localparam int IW   = ogn_pkg::IDX_W;

  logic [ogn_pkg::OCT_W-1:0] octave_count;
  logic [ogn_pkg::OCT_W-1:0] oct_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= ogn_pkg::OCT_W'(1);
    end else if (cfg_wr_en) begin
      octave_count <= cfg_wr_data;
    end
  end

  assign oct_lim = (octave_count > ogn_pkg::OCT_W'(NOCT)) ? ogn_pkg::OCT_W'(NOCT)
                                                         : octave_count;

  logic            adv;
  logic [NSTG-1:0] vld, vld_next;

  assign adv        = !vld[NSTG-1] || result.ready;
  assign item.ready = adv;

  logic               req1, req2, req3;
  logic [IW-1:0]      idx1, idx2, idx3;
  logic [7:0]         val1, val2, val3;
  logic [CW-1:0]      px1, py1;

  always_comb begin
    vld_next    = {vld[NSTG-2:0], item.valid};
    vld_next[3] = vld[2] && (req3 == ogn_pkg::REQ_EVAL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      req1 <= item.req_type;
      idx1 <= IW'(item.table_index);
      val1 <= item.table_value;
      px1  <= CW'(item.x_coord);
      py1  <= CW'(item.y_coord);
      req2 <= req1;
      idx2 <= idx1;
      val2 <= val1;
      req3 <= req2;
      idx3 <= idx2;
      val3 <= val2;
    end
  end

  ogn_pkg::tbl_wr_t wr;

  assign wr.we[0]  = vld[0] && (req1 == ogn_pkg::REQ_LOAD);
  assign wr.we[1]  = vld[1] && (req2 == ogn_pkg::REQ_LOAD);
  assign wr.we[2]  = vld[2] && (req3 == ogn_pkg::REQ_LOAD);
  assign wr.idx[0] = idx1;
  assign wr.idx[1] = idx2;
  assign wr.idx[2] = idx3;
  assign wr.val[0] = val1;
  assign wr.val[1] = val2;
  assign wr.val[2] = val3;

  logic signed [20:0] lane_n [NOCT];
  logic signed [20:0] term   [NOCT];

  for (genvar l = 0; l < NOCT; l++) begin : g_lane
    localparam int HALF = (1 << l) >> 1;

    ogn_octave u_octave (
      .clk (clk),
      .adv (adv),
      .wr  (wr),
      .cx  (CW'(px1 << l)),
      .cy  (CW'(py1 << l)),
      .n   (lane_n[l])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        if (ogn_pkg::OCT_W'(l) < oct_lim) begin
          term[l] <= (lane_n[l] + 21'(HALF)) >>> l;
        end else begin
          term[l] <= '0;
        end
      end
    end
  end

  logic signed [21:0] psum [NOCT/2];
  logic signed [23:0] tot;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NOCT / 2; k++) begin
        psum[k] <= 22'(term[2*k]) + 22'(term[2*k+1]);
      end
      tot <= 24'(psum[0]) + 24'(psum[1]) + 24'(psum[2]) + 24'(psum[3]);
    end
  end

  logic signed [23:0] half_sum;
  logic signed [17:0] raw_next;
  logic [15:0]        unit_next;
  logic signed [17:0] raw;
  logic [15:0]        unit;

  always_comb begin
    half_sum = ((tot + 24'sd1) >>> 1) + 24'sd32768;
    if (tot < -24'sd131072) begin
      raw_next = -18'sd131072;
    end else if (tot > 24'sd131071) begin
      raw_next = 18'sd131071;
    end else begin
      raw_next = 18'(tot);
    end
    if (half_sum < 24'sd0) begin
      unit_next = 16'd0;
    end else if (half_sum > 24'sd65535) begin
      unit_next = 16'hffff;
    end else begin
      unit_next = 16'(half_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      raw  <= raw_next;
      unit <= unit_next;
    end
  end

  assign result.valid      = vld[NSTG-1];
  assign result.raw_sum    = raw;
  assign result.noise_unit = unit;

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_pos_upper: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.raw_sum[17] |-> result.noise_unit >= 16'h8000)
    else $error("non-negative sum mapped below one half");

  a_neg_lower: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.raw_sum[17] |-> result.noise_unit <= 16'h8000)
    else $error("negative sum mapped above one half");

  a_zero_octaves: assert property (@(posedge clk) disable iff (rst)
    vld[9] && octave_count == '0 |-> tot == '0)
    else $error("zero octaves gave a nonzero sum");

endmodule

`default_nettype wire

/* rtl/ogn_octave.sv */
// One octave lane: three permutation lookup levels, fade, gradients and blends.
// Depends on ogn_pkg. Holds its own copies of the permutation table.
`default_nettype none

module ogn_octave (
  input  logic                            clk,
  input  logic                            adv,
  input  ogn_pkg::tbl_wr_t                wr,
  input  logic [ogn_pkg::COORD_W-1:0]     cx,
  input  logic [ogn_pkg::COORD_W-1:0]     cy,
  output logic signed [20:0]              n
);

  localparam int FB = ogn_pkg::FRAC_BITS;
  localparam int IW = ogn_pkg::IDX_W;

  logic [7:0] mem_a  [ogn_pkg::TABLE_SIZE];
  logic [7:0] mem_b0 [ogn_pkg::TABLE_SIZE];
  logic [7:0] mem_b1 [ogn_pkg::TABLE_SIZE];
  logic [7:0] mem_c0 [ogn_pkg::TABLE_SIZE];
  logic [7:0] mem_c1 [ogn_pkg::TABLE_SIZE];

  // stage 1
  logic [IW-1:0]      xi, yi;
  logic signed [16:0] tx, ty;
  logic signed [23:0] p0x, p0y;

  assign xi  = cx[FB +: IW];
  assign yi  = cy[FB +: IW];
  assign tx  = $signed({1'b0, cx[FB-1:0]});
  assign ty  = $signed({1'b0, cy[FB-1:0]});
  assign p0x = 24'(24'(tx) * 24'sd6) - 24'(15 * ogn_pkg::ONE);
  assign p0y = 24'(24'(ty) * 24'sd6) - 24'(15 * ogn_pkg::ONE);

  logic [7:0]         pa, pb;
  logic [IW-1:0]      yi2;
  logic signed [16:0] tx2, ty2;
  logic signed [47:0] mx1, my1;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr.we[0]) begin
        mem_a[wr.idx[0]] <= wr.val[0];
      end
      pa  <= mem_a[xi];
      pb  <= mem_a[IW'(xi + 1'b1)];
      yi2 <= yi;
      tx2 <= tx;
      ty2 <= ty;
      mx1 <= 48'(tx) * 48'(p0x);
      my1 <= 48'(ty) * 48'(p0y);
    end
  end

  // stage 2
  logic [IW-1:0]      a, b;
  logic signed [23:0] qx2, qy2;

  assign a   = IW'(pa + yi2);
  assign b   = IW'(pb + yi2);
  assign qx2 = 24'(ogn_pkg::rnd_frac(mx1)) + 24'(10 * ogn_pkg::ONE);
  assign qy2 = 24'(ogn_pkg::rnd_frac(my1)) + 24'(10 * ogn_pkg::ONE);

  logic [7:0]         raa, rab, rba, rbb;
  logic signed [16:0] tx3, ty3;
  logic signed [47:0] mx2, my2;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr.we[1]) begin
        mem_b0[wr.idx[1]] <= wr.val[1];
        mem_b1[wr.idx[1]] <= wr.val[1];
      end
      raa <= mem_b0[a];
      rab <= mem_b0[IW'(a + 1'b1)];
      rba <= mem_b1[b];
      rbb <= mem_b1[IW'(b + 1'b1)];
      tx3 <= tx2;
      ty3 <= ty2;
      mx2 <= 48'(tx2) * 48'(qx2);
      my2 <= 48'(ty2) * 48'(qy2);
    end
  end

  // stage 3
  logic [7:0]         haa, hab, hba, hbb;
  logic signed [16:0] tx4, ty4;
  logic signed [47:0] mx3, my3;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr.we[2]) begin
        mem_c0[wr.idx[2]] <= wr.val[2];
        mem_c1[wr.idx[2]] <= wr.val[2];
      end
      haa <= mem_c0[raa];
      hab <= mem_c0[rab];
      hba <= mem_c1[rba];
      hbb <= mem_c1[rbb];
      tx4 <= tx3;
      ty4 <= ty3;
      mx3 <= 48'(tx3) * 48'(24'(ogn_pkg::rnd_frac(mx2)));
      my3 <= 48'(ty3) * 48'(24'(ogn_pkg::rnd_frac(my2)));
    end
  end

  // stage 4
  logic signed [17:0] x0, y0, x1, y1;

  assign x0 = 18'(tx4);
  assign y0 = 18'(ty4);
  assign x1 = x0 - 18'(ogn_pkg::ONE);
  assign y1 = y0 - 18'(ogn_pkg::ONE);

  logic signed [18:0] gaa, gab, gba, gbb;
  logic signed [47:0] mx4, my4;

  always_ff @(posedge clk) begin
    if (adv) begin
      gaa <= ogn_pkg::grad(haa[3:0], x0, y0);
      gba <= ogn_pkg::grad(hba[3:0], x1, y0);
      gab <= ogn_pkg::grad(hab[3:0], x0, y1);
      gbb <= ogn_pkg::grad(hbb[3:0], x1, y1);
      mx4 <= 48'(tx4) * 48'(24'(ogn_pkg::rnd_frac(mx3)));
      my4 <= 48'(ty4) * 48'(24'(ogn_pkg::rnd_frac(my3)));
    end
  end

  // stage 5
  logic signed [17:0] u, v;
  logic signed [19:0] d_lo, d_hi;

  assign u    = 18'(ogn_pkg::rnd_frac(mx4));
  assign v    = 18'(ogn_pkg::rnd_frac(my4));
  assign d_lo = 20'(gba) - 20'(gaa);
  assign d_hi = 20'(gbb) - 20'(gab);

  logic signed [47:0] m_lo, m_hi;
  logic signed [18:0] gaa5, gab5;
  logic signed [17:0] v5;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_lo <= 48'(u) * 48'(d_lo);
      m_hi <= 48'(u) * 48'(d_hi);
      gaa5 <= gaa;
      gab5 <= gab;
      v5   <= v;
    end
  end

  // stage 6
  logic signed [20:0] lo, hi;

  assign lo = 21'(gaa5) + 21'(ogn_pkg::rnd_frac(m_lo));
  assign hi = 21'(gab5) + 21'(ogn_pkg::rnd_frac(m_hi));

  logic signed [47:0] m_n;
  logic signed [20:0] lo6;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_n <= 48'(v5) * 48'(21'(hi - lo));
      lo6 <= lo;
    end
  end

  // stage 7
  assign n = lo6 + 21'(ogn_pkg::rnd_frac(m_n));

endmodule

`default_nettype wire

/* bench/ogn_noise_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the octave gradient noise core: mirrors the permutation table and
// octave count, predicts each point's result and compares result beats in order.
// Depends on ogn_pkg, ogn_in_if and ogn_out_if.
`default_nettype none

module ogn_noise_checker (
  input  logic      clk,
  input  logic      rst,
  ogn_in_if         item,
  ogn_out_if        result,
  input  logic      cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  output int        errors,
  output int        pending,
  output int        points_seen,
  output int        loads_seen
);

  typedef struct {
    logic signed [17:0] raw_sum;
    logic [15:0]        noise_unit;
  } noise_res_t;

  localparam longint UNIT  = 64'sd1 <<< 16;
  localparam longint CMASK = (64'sd1 <<< 24) - 1;

  logic [7:0]  perm_copy [256];
  logic [3:0]  octaves;
  noise_res_t  expected_q[$];

  function automatic longint rnd_sh(input longint v, input int k);
    if (k == 0) return v;
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic longint fade_q(input longint t);
    longint p;
    p = 6 * t - 15 * UNIT;
    p = rnd_sh(t * p, 16) + 10 * UNIT;
    p = rnd_sh(t * p, 16);
    p = rnd_sh(t * p, 16);
    p = rnd_sh(t * p, 16);
    return p;
  endfunction

  function automatic longint mix(input longint t, input longint a, input longint b);
    return a + rnd_sh(t * (b - a), 16);
  endfunction

  function automatic longint corner_grad(input int hash, input longint gx, input longint gy);
    int h;
    longint u;
    longint v;
    h = hash & 15;
    u = (h < 8) ? gx : gy;
    v = (h < 4) ? gy : ((h == 12 || h == 14) ? gx : 0);
    return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
  endfunction

  function automatic int pt(input int i);
    return int'(perm_copy[i & 255]);
  endfunction

  function automatic longint slice_noise(input longint cx, input longint cy);
    int xi, yi, a, b, aa, ab, ba, bb;
    longint x0, y0, x1, y1, u, v, lo, hi;
    xi = int'((cx >> 16) & 255);
    yi = int'((cy >> 16) & 255);
    x0 = cx & (UNIT - 1);
    y0 = cy & (UNIT - 1);
    x1 = x0 - UNIT;
    y1 = y0 - UNIT;
    u  = fade_q(x0);
    v  = fade_q(y0);
    a  = pt(xi) + yi;
    b  = pt(xi + 1) + yi;
    aa = pt(a);
    ab = pt(a + 1);
    ba = pt(b);
    bb = pt(b + 1);
    lo = mix(u, corner_grad(pt(aa), x0, y0), corner_grad(pt(ba), x1, y0));
    hi = mix(u, corner_grad(pt(ab), x0, y1), corner_grad(pt(bb), x1, y1));
    return mix(v, lo, hi);
  endfunction

  function automatic noise_res_t predict_point(input logic [23:0] xr, input logic [23:0] yr);
    longint cx, cy, sum, unit;
    int n;
    noise_res_t r;
    cx  = longint'(xr) & CMASK;
    cy  = longint'(yr) & CMASK;
    sum = 0;
    n   = (octaves > ogn_pkg::MAX_OCTAVES) ? ogn_pkg::MAX_OCTAVES : int'(octaves);
    for (int i = 0; i < n; i++) begin
      sum += rnd_sh(slice_noise(cx, cy), i);
      cx = (cx << 1) & CMASK;
      cy = (cy << 1) & CMASK;
    end
    unit = rnd_sh(sum, 1) + 32768;
    if (unit < 0) unit = 0;
    if (unit > 65535) unit = 65535;
    if (sum < -131072) sum = -131072;
    if (sum > 131071) sum = 131071;
    r.raw_sum    = sum[17:0];
    r.noise_unit = unit[15:0];
    return r;
  endfunction

  assign pending = expected_q.size();

  initial begin
    errors      = 0;
    points_seen = 0;
    loads_seen  = 0;
    octaves     = 4'd1;
    foreach (perm_copy[i]) perm_copy[i] = 8'd0;
  end

  always @(posedge clk) begin
    noise_res_t e;
    if (rst) begin
      octaves <= 4'd1;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat raw_sum=%0d noise_unit=%0d",
                   $time, result.raw_sum, result.noise_unit);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (result.raw_sum !== e.raw_sum) begin
            $display("%0t: raw_sum expected %0d actual %0d", $time, e.raw_sum,
                     result.raw_sum);
            errors++;
          end
          if (result.noise_unit !== e.noise_unit) begin
            $display("%0t: noise_unit expected %0d actual %0d", $time, e.noise_unit,
                     result.noise_unit);
            errors++;
          end
        end
      end
      if (item.valid && item.ready) begin
        if (item.req_type == ogn_pkg::REQ_LOAD) begin
          perm_copy[item.table_index] = item.table_value;
          loads_seen++;
        end else begin
          expected_q = {expected_q, predict_point(item.x_coord, item.y_coord)};
          points_seen++;
        end
      end
      if (cfg_wr_en) octaves <= cfg_wr_data;
    end
  end

endmodule

`default_nettype wire

/* bench/octave_gradient_noise_2d_core_tb.sv */
`timescale 1ns / 100ps
// Top of the noise core bench: clock, reset, table fill, directed and random points
// over several octave counts, result-side stalls, watchdog and verdict.
// Depends on ogn_pkg, ogn_in_if, ogn_out_if, ogn_noise_checker and the core.
`default_nettype none

module octave_gradient_noise_2d_core_tb;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN      = 12;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [3:0] cfg_wr_data = 4'd0;
  int         errors, pending, points_seen, loads_seen;
  int         idle_cycles = 0;
  int         stall_left = 0;

  ogn_in_if  item ();
  ogn_out_if result ();

  octave_gradient_noise_2d_core dut (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  ogn_noise_checker chk (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .errors      (errors),
    .pending     (pending),
    .points_seen (points_seen),
    .loads_seen  (loads_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    item.valid       = 1'b0;
    item.req_type    = ogn_pkg::REQ_LOAD;
    item.table_index = 8'd0;
    item.table_value = 8'd0;
    item.x_coord     = 24'sd0;
    item.y_coord     = 24'sd0;
    result.ready     = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result-side backpressure
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      result.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      result.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_beat(input ogn_pkg::req_t kind, input logic [7:0] idx,
                           input logic [7:0] val, input logic [23:0] xc,
                           input logic [23:0] yc);
    int g;
    item.valid       <= 1'b1;
    item.req_type    <= kind;
    item.table_index <= idx;
    item.table_value <= val;
    item.x_coord     <= xc;
    item.y_coord     <= yc;
    do @(posedge clk); while (!item.ready);
    g = gap_len();
    if (g > 0) begin
      item.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_point(input logic [23:0] xc, input logic [23:0] yc);
    send_beat(ogn_pkg::REQ_EVAL, 8'($urandom), 8'($urandom), xc, yc);
  endtask

  task automatic send_load(input logic [7:0] idx, input logic [7:0] val);
    send_beat(ogn_pkg::REQ_LOAD, idx, val, 24'($urandom), 24'($urandom));
  endtask

  task automatic set_octaves(input logic [3:0] n);
    item.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [7:0] shuffle [256];
    logic [7:0] tmp;
    int j;
    logic [3:0] phase_oct [7];

    phase_oct = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd3, 4'($urandom_range(0, 15)), 4'd8};
    foreach (shuffle[i]) shuffle[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = shuffle[i];
      shuffle[i] = shuffle[j];
      shuffle[j] = tmp;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every table entry before any lookup
    for (int i = 0; i < 256; i++) send_load(8'(i), shuffle[i]);

    // directed points at reset octave count, then at maximum and saturated counts
    for (int k = 0; k < 3; k++) begin
      send_point(24'h000000, 24'h000000);
      send_point(24'h7FFFFF, 24'h7FFFFF);
      send_point(24'h800000, 24'h800000);
      send_point(24'h00FFFF, 24'hFFFFFF);
      send_point(24'hFF8000, 24'h008000);
      send_point(24'h123456, 24'hFEDCBA);
      send_point(24'h010000, 24'h7F0001);
      if (k == 0) set_octaves(4'd8);
      if (k == 1) set_octaves(4'd15);
    end
    set_octaves(4'd0);
    send_point(24'h7FFFFF, 24'h800000);
    send_load(8'hFF, 8'h00);
    send_load(8'h00, 8'hFF);

    foreach (phase_oct[p]) begin
      set_octaves(phase_oct[p]);
      for (int i = 0; i < 82; i++) begin
        if ($urandom_range(0, 99) < 85) send_point(24'($urandom), 24'($urandom));
        else send_load(8'($urandom), 8'($urandom));
      end
    end

    item.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Checked %0d points and %0d table loads over octave counts 0..15.",
             points_seen, loads_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
